FILE: hw/rtl/m3i_pkg.sv
// Types, constants and arithmetic helpers shared by the 3x3 matrix inverse.
package m3i_pkg;

  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned COF_W      = 64;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned DET_W      = 100;
  localparam int unsigned QBITS      = 31;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic [3:0] idx_t;

  // cofactor k = m[A]*m[B] - m[C]*m[D]
  localparam idx_t COF_A [9] = '{4'd4, 4'd6, 4'd3, 4'd7, 4'd0, 4'd6, 4'd1, 4'd3, 4'd0};
  localparam idx_t COF_B [9] = '{4'd8, 4'd5, 4'd7, 4'd2, 4'd8, 4'd1, 4'd5, 4'd2, 4'd4};
  localparam idx_t COF_C [9] = '{4'd7, 4'd3, 4'd6, 4'd1, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
  localparam idx_t COF_D [9] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd7, 4'd2, 4'd5, 4'd1};

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } mat_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic signed [ELEM_W-1:0] determinant;
    logic                     invertible;
  } mat_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [8:0][COF_W-1:0]  cof;
    logic [8:0][ELEM_W-1:0] mat;
    logic [ELEM_W-1:0]      det;
    logic                   inv;
  } fe_t;

  function automatic logic signed [63:0] smul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = {{32{a[31]}}, a};
    eb = {{32{b[31]}}, b};
    return ea * eb;
  endfunction

  function automatic logic signed [64:0] sumul(logic signed [31:0] a, logic [31:0] b);
    logic signed [64:0] ea;
    logic signed [64:0] eb;
    ea = {{33{a[31]}}, a};
    eb = {33'b0, b};
    return ea * eb;
  endfunction

endpackage

FILE: hw/rtl/m3i_if.sv
// Valid/ready channel interfaces for matrix beats in and result beats out.
interface m3i_in_if;
  import m3i_pkg::*;
  logic    valid;
  logic    ready;
  mat_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface m3i_out_if;
  import m3i_pkg::*;
  logic     valid;
  logic     ready;
  mat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/m3i_front.sv
// Front pipeline: cofactors, determinant, rounding and threshold classification.
module m3i_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  m3i_pkg::mat_in_t                  in_data_i,
  input  logic [m3i_pkg::THR_W-1:0]         thr_i,
  output logic                              push_o,
  input  logic                              full_i,
  output m3i_pkg::fe_t                      item_o
);
  import m3i_pkg::*;

  logic signed [ELEM_W-1:0] m [9];
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic [8:0][ELEM_W-1:0] mat1_q, mat2_q, mat3_q, mat4_q, mat5_q;
  logic signed [COF_W-1:0] pa1_q [9];
  logic signed [COF_W-1:0] pb1_q [9];
  logic [8:0][COF_W-1:0] cof2_q, cof3_q, cof4_q, cof5_q;
  logic signed [64:0] pl3_q [3];
  logic signed [63:0] ph3_q [3];
  logic signed [DET_W-1:0] t4_q [3];
  logic signed [DET_W-1:0] det5_q;
  fe_t item6_q;

  logic [ELEM_W-1:0] d_sat;
  logic [ELEM_W-1:0] d_mag;
  logic              fits;

  always_comb begin
    m[0] = in_data_i.m00;
    m[1] = in_data_i.m01;
    m[2] = in_data_i.m02;
    m[3] = in_data_i.m10;
    m[4] = in_data_i.m11;
    m[5] = in_data_i.m12;
    m[6] = in_data_i.m20;
    m[7] = in_data_i.m21;
    m[8] = in_data_i.m22;
  end

  assign en         = !(v6_q && full_i);
  assign in_ready_o = en;
  assign push_o     = v6_q && !full_i;
  assign item_o     = item6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // rounded determinant, saturated to 32 bits
  always_comb begin
    fits  = (&det5_q[DET_W-1:63]) || !(|det5_q[DET_W-1:63]);
    d_sat = fits ? det5_q[63:32] : (det5_q[DET_W-1] ? SAT_MIN : SAT_MAX);
    d_mag = d_sat[ELEM_W-1] ? (~d_sat + 1'b1) : d_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        mat1_q[k] <= m[k];
        pa1_q[k]  <= smul(m[COF_A[k]], m[COF_B[k]]);
        pb1_q[k]  <= smul(m[COF_C[k]], m[COF_D[k]]);
        cof2_q[k] <= pa1_q[k] - pb1_q[k];
      end
      mat2_q <= mat1_q;
      for (int k = 0; k < 3; k++) begin
        pl3_q[k] <= sumul($signed(mat2_q[k]), cof2_q[k][31:0]);
        ph3_q[k] <= smul($signed(mat2_q[k]), $signed(cof2_q[k][63:32]));
        t4_q[k]  <= $signed({{(DET_W-96){ph3_q[k][63]}}, ph3_q[k], 32'b0})
                  + $signed({{(DET_W-65){pl3_q[k][64]}}, pl3_q[k]});
      end
      mat3_q <= mat2_q;
      cof3_q <= cof2_q;
      mat4_q <= mat3_q;
      cof4_q <= cof3_q;
      det5_q <= t4_q[0] + t4_q[1] + t4_q[2]
              + $signed({{(DET_W-32){1'b0}}, 32'h8000_0000});
      mat5_q <= mat4_q;
      cof5_q <= cof4_q;
      item6_q.cof <= cof5_q;
      item6_q.mat <= mat5_q;
      item6_q.det <= d_sat;
      item6_q.inv <= d_mag > {1'b0, thr_i};
    end
  end

endmodule

FILE: hw/rtl/m3i_fifo.sv
// Small register queue between the front and back pipelines.
module m3i_fifo #(
  parameter int unsigned Depth = m3i_pkg::FIFO_DEPTH,
  parameter type         T     = m3i_pkg::fe_t
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  T mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/m3i_back.sv
// Back pipeline: nine restoring dividers, one quotient bit per stage, and output register.
module m3i_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  m3i_pkg::fe_t       item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output m3i_pkg::mat_out_t  out_data_o
);
  import m3i_pkg::*;

  typedef struct packed {
    logic [31:0]      rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] quo;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]            lane;
    logic [8:0][ELEM_W-1:0] mat;
    logic [ELEM_W-1:0]      md;
    logic [ELEM_W-1:0]      det;
    logic                   inv;
  } bk_t;

  function automatic bk_t bk_step(bk_t b);
    bk_t r;
    logic [32:0] t;
    logic        ge;
    r = b;
    for (int n = 0; n < 9; n++) begin
      t  = {b.lane[n].rem, b.lane[n].low[QBITS-1]};
      ge = t >= {1'b0, b.md};
      r.lane[n].rem = ge ? 32'(t - {1'b0, b.md}) : t[31:0];
      r.lane[n].low = {b.lane[n].low[QBITS-2:0], 1'b0};
      r.lane[n].quo = {b.lane[n].quo[QBITS-2:0], ge};
    end
    return r;
  endfunction

  logic en;
  bk_t  init;
  bk_t  bs_q [QBITS+1];
  logic [QBITS:0] bv_q;
  logic out_valid_q;
  mat_out_t out_q;
  logic [8:0][ELEM_W-1:0] res;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    init.mat = item_i.mat;
    init.det = item_i.det;
    init.inv = item_i.inv;
    init.md  = item_i.det[ELEM_W-1] ? (~item_i.det + 1'b1) : item_i.det;
  end

  for (genvar n = 0; n < 9; n++) begin : g_lane
    localparam int unsigned CI = 3 * (n % 3) + n / 3;
    logic [COF_W-1:0] mc;
    logic [COF_W-1:0] num;
    always_comb begin
      mc  = item_i.cof[CI][COF_W-1] ? (~item_i.cof[CI] + 1'b1) : item_i.cof[CI];
      num = mc + {33'b0, init.md[31:1]};
      init.lane[n].rem = num[62:31];
      init.lane[n].low = num[30:0];
      init.lane[n].quo = '0;
      init.lane[n].ovf = num[63:31] >= {1'b0, init.md};
      init.lane[n].neg = item_i.cof[CI][COF_W-1] ^ item_i.det[ELEM_W-1];
    end

    always_comb begin
      if (!bs_q[QBITS].inv) begin
        res[n] = bs_q[QBITS].mat[n];
      end else if (bs_q[QBITS].lane[n].ovf) begin
        res[n] = bs_q[QBITS].lane[n].neg ? SAT_MIN : SAT_MAX;
      end else if (bs_q[QBITS].lane[n].neg) begin
        res[n] = ~{1'b0, bs_q[QBITS].lane[n].quo} + 1'b1;
      end else begin
        res[n] = {1'b0, bs_q[QBITS].lane[n].quo};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      bv_q        <= {bv_q[QBITS-1:0], !empty_i};
      out_valid_q <= bv_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bs_q[0] <= init;
      for (int s = 1; s <= QBITS; s++) begin
        bs_q[s] <= bk_step(bs_q[s-1]);
      end
      out_q.r00         <= res[0];
      out_q.r01         <= res[1];
      out_q.r02         <= res[2];
      out_q.r10         <= res[3];
      out_q.r11         <= res[4];
      out_q.r12         <= res[5];
      out_q.r20         <= res[6];
      out_q.r21         <= res[7];
      out_q.r22         <= res[8];
      out_q.determinant <= bs_q[QBITS].det;
      out_q.invertible  <= bs_q[QBITS].inv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/matrix3_inverse.sv
// Top level of the 3x3 Q16.16 matrix inverse by adjugate.
//
// in_i carries one matrix per beat (nine signed Q16.16 elements, row-major);
// out_o carries one result beat per matrix: the inverse or the unchanged
// input, the rounded determinant and the invertible flag. Both channels use
// valid/ready; a beat moves when both are high.
// cfg_we_i/cfg_wdata_i write det_threshold; write it only while idle.
// Throughput: one matrix per cycle unless the receiver stalls. A beat passes
// the six-stage determinant front, the queue slot and the 31 quotient-bit
// stages of the dividers plus the output register on its way to out_o.
// Reset clears all valid bits and the queue and sets det_threshold to 1.
// When the receiver stalls, the output register and divider pipeline hold;
// the front keeps taking beats until the queue between front and back
// fills, then in_i.ready drops.
module matrix3_inverse #(
  parameter int unsigned FifoDepth = m3i_pkg::FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  m3i_in_if.sink                     in_i,
  m3i_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [m3i_pkg::THR_W-1:0]  cfg_wdata_i
);
  import m3i_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic push, full, pop, empty;
  fe_t  fe_item, bk_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  m3i_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data),
    .thr_i      (thr_q),
    .push_o     (push),
    .full_i     (full),
    .item_o     (fe_item)
  );

  m3i_fifo #(
    .Depth (FifoDepth),
    .T     (fe_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fe_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (bk_item),
    .empty_o (empty)
  );

  m3i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (bk_item),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

FILE: hw/rtl/m3i_checker.sv
// Port-level assertions for the matrix inverse, bound to the top level.
module m3i_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input m3i_pkg::mat_out_t  out_data_i
);
  import m3i_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result beat valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result beat changed while stalled");

  a_inv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.invertible |-> out_data_i.determinant != '0)
    else $error("inverse reported with zero determinant");

  a_min_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.determinant == SAT_MIN |-> out_data_i.invertible)
    else $error("most negative determinant not treated as invertible");

endmodule

bind matrix3_inverse m3i_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
